// ===== design/nntu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nntu_pkg
// Shared types and constants of the nearest neighbor tour unit.
// ----------------------------------------------------------------------------
package nntu_pkg;

  // port field widths
  localparam int CITY_W      = 4;
  localparam int WEIGHT_IN_W = 16;
  localparam int COST_W      = 24;
  localparam int CNT_W       = 5;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TOUR = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CITY_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NO_EDGE    = 1'b1;

  // reset values of the configuration registers
  localparam logic [CNT_W-1:0] CITY_COUNT_RST = 5'd10;
  localparam logic [CFG_W-1:0] NO_EDGE_RST    = 16'd666;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_CLOSE = 4'b1000
  } state_e;

endpackage

// ===== design/nntu_weight_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nntu_weight_ram
// Weight store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module nntu_weight_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/nearest_neighbor_tour_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_tour_unit
// Greedy nearest neighbor tour builder over a square weight store.
// ----------------------------------------------------------------------------
// A load transaction (cmd 0) writes one weight and busy stays low, so
// loads can follow back to back. A tour transaction (cmd 1) raises busy
// until the closing result has been sent. The start city comes out in the
// cycle after the start; after that every step scans one row of the weight
// store through the single read port of the memory, one entry per cycle,
// and then a decision state (ST_DRAIN) picks the next city. The final
// failing scan is followed by ST_CLOSE, which reads the closing edge and
// sends the closing result. Results are strobed by valid_o for exactly one
// cycle and cannot be held off; total_cost_o is meaningful only with last_o
// and reads zero with the other results of a tour.
module nearest_neighbor_tour_unit #(
  parameter int MAX_CITIES  = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // command channel
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic                                 cmd_i,
  input  logic [nntu_pkg::CITY_W-1:0]          from_city_i,
  input  logic [nntu_pkg::CITY_W-1:0]          to_city_i,
  input  logic [nntu_pkg::WEIGHT_IN_W-1:0]     weight_i,
  input  logic [nntu_pkg::CITY_W-1:0]          start_city_i,
  // result channel
  output logic                                 valid_o,
  output logic [nntu_pkg::CITY_W-1:0]          city_o,
  output logic [nntu_pkg::COST_W-1:0]          total_cost_o,
  output logic                                 last_o,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [nntu_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [nntu_pkg::CFG_W-1:0]           cfg_data_i
);

  import nntu_pkg::*;

  localparam int CITY_BITS = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
  localparam int DEPTH     = MAX_CITIES * MAX_CITIES;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CMP_W     = (WEIGHT_BITS > CFG_W) ? WEIGHT_BITS : CFG_W;
  localparam int SUM_W     = ((COST_W > WEIGHT_BITS) ? COST_W : WEIGHT_BITS) + 1;

  // configuration
  logic [CNT_W-1:0] city_count_q;
  logic [CFG_W-1:0] no_edge_q;

  // control and datapath state
  state_e                 state_q, state_d;
  logic [CITY_BITS-1:0]   cur_q, cur_d;
  logic [CITY_BITS-1:0]   start_q, start_d;
  logic [CITY_BITS-1:0]   last_q, last_d;
  logic [CITY_BITS-1:0]   idx_q, idx_d;
  logic [CITY_BITS-1:0]   cmp_idx_q;
  logic                   cmp_vld_q, cmp_vld_d;
  logic                   found_q, found_d;
  logic [CITY_BITS-1:0]   best_q, best_d;
  logic [WEIGHT_BITS-1:0] best_w_q, best_w_d;
  logic [MAX_CITIES-1:0]  visited_q, visited_d;
  logic [COST_W-1:0]      cost_q, cost_d;

  // result registers
  logic                   valid_q, valid_d;
  logic [CITY_BITS-1:0]   city_q, city_d;
  logic [COST_W-1:0]      total_q, total_d;
  logic                   last_res_q, last_res_d;

  // memory ports
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [WEIGHT_BITS-1:0] mem_wdata;
  logic [ADDR_W-1:0]      mem_raddr;
  logic [WEIGHT_BITS-1:0] mem_rdata;

  // helpers
  logic                   accept;
  logic [CITY_BITS-1:0]   last_city;
  logic [CITY_BITS-1:0]   start_clamp;
  logic                   load_in_range;
  logic                   candidate;
  logic [WEIGHT_BITS-1:0] add_w;
  logic [SUM_W-1:0]       sum;
  logic [COST_W-1:0]      cost_sat;
  logic [CITY_BITS-1:0]   rd_col;

  nntu_weight_ram #(
    .WIDTH  (WEIGHT_BITS),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign accept = start_i && !busy_o;

  // cities in use minus one, with the count clamped to 1..MAX_CITIES
  always_comb begin
    if (city_count_q == '0) begin
      last_city = '0;
    end else if (int'(city_count_q) > MAX_CITIES) begin
      last_city = CITY_BITS'(MAX_CITIES - 1);
    end else begin
      last_city = CITY_BITS'(city_count_q - CNT_W'(1));
    end
  end

  assign start_clamp = (int'(start_city_i) > int'(last_city)) ? last_city
                                                              : CITY_BITS'(start_city_i);

  assign load_in_range = (int'(from_city_i) < MAX_CITIES) && (int'(to_city_i) < MAX_CITIES);

  assign mem_we    = accept && (cmd_i == CMD_LOAD) && load_in_range;
  assign mem_waddr = ADDR_W'(int'(from_city_i) * MAX_CITIES + int'(to_city_i));
  assign mem_wdata = WEIGHT_BITS'(weight_i);

  // scan reads walk the row; the decision cycle fetches the closing edge
  assign rd_col    = (state_q == ST_SCAN) ? idx_q : start_q;
  assign mem_raddr = ADDR_W'(int'(cur_q) * MAX_CITIES + int'(rd_col));

  // compare the entry that arrived from memory against the best so far
  assign candidate = cmp_vld_q && (mem_rdata != '0) &&
                     (CMP_W'(mem_rdata) != CMP_W'(no_edge_q)) && !visited_q[cmp_idx_q];

  always_comb begin
    found_d  = found_q;
    best_d   = best_q;
    best_w_d = best_w_q;
    if (candidate && (!found_q || (mem_rdata < best_w_q))) begin
      found_d  = 1'b1;
      best_d   = cmp_idx_q;
      best_w_d = mem_rdata;
    end
  end

  // saturating cost adder, shared by the step and the closing edge
  assign add_w    = (state_q == ST_CLOSE) ? mem_rdata : best_w_d;
  assign sum      = SUM_W'(cost_q) + SUM_W'(add_w);
  assign cost_sat = (sum > SUM_W'(COST_MAX)) ? COST_MAX : COST_W'(sum);

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    start_d    = start_q;
    last_d     = last_q;
    idx_d      = idx_q;
    cmp_vld_d  = 1'b0;
    visited_d  = visited_q;
    cost_d     = cost_q;
    valid_d    = 1'b0;
    city_d     = city_q;
    total_d    = total_q;
    last_res_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept && (cmd_i == CMD_TOUR)) begin
          start_d              = start_clamp;
          last_d               = last_city;
          cur_d                = start_clamp;
          visited_d            = '0;
          visited_d[start_clamp] = 1'b1;
          cost_d               = '0;
          idx_d                = '0;
          valid_d              = 1'b1;
          city_d               = start_clamp;
          total_d              = '0;
          state_d              = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmp_vld_d = 1'b1;
        if (idx_q == last_q) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + CITY_BITS'(1);
        end
      end
      ST_DRAIN: begin
        if (found_d) begin
          cost_d            = cost_sat;
          visited_d[best_d] = 1'b1;
          cur_d             = best_d;
          valid_d           = 1'b1;
          city_d            = best_d;
          total_d           = '0;
          idx_d             = '0;
          state_d           = ST_SCAN;
        end else begin
          state_d = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        valid_d    = 1'b1;
        city_d     = start_q;
        total_d    = cost_sat;
        last_res_d = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      city_count_q <= CITY_COUNT_RST;
      no_edge_q    <= NO_EDGE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CITY_COUNT: city_count_q <= cfg_data_i[CNT_W-1:0];
        REG_NO_EDGE:    no_edge_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cmp_vld_q  <= 1'b0;
      valid_q    <= 1'b0;
      last_res_q <= 1'b0;
      visited_q  <= '0;
      cur_q      <= '0;
      cost_q     <= '0;
      found_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      cmp_vld_q  <= cmp_vld_d;
      valid_q    <= valid_d;
      last_res_q <= last_res_d;
      visited_q  <= visited_d;
      cur_q      <= cur_d;
      cost_q     <= cost_d;
      // best-so-far restarts at the top of every row scan
      found_q    <= (state_q == ST_SCAN) ? found_d : 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    start_q   <= start_d;
    last_q    <= last_d;
    idx_q     <= idx_d;
    cmp_idx_q <= idx_q;
    best_q    <= best_d;
    best_w_q  <= best_w_d;
    city_q    <= city_d;
    total_q   <= total_d;
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign valid_o      = valid_q;
  assign city_o       = CITY_W'(city_q);
  assign total_cost_o = total_q;
  assign last_o       = last_res_q;

  // the start city stays marked for the whole tour
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> visited_q[start_q])
    else $error("start city not marked visited during tour");

  // a tour start yields the start city as an ordinary result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (cmd_i == CMD_TOUR)) |=>
      (valid_o && !last_o && busy_o && (total_cost_o == '0)))
    else $error("tour start did not emit the start city");

  // the closing result always returns to the start city and ends the tour
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |-> ((city_q == start_q) && !busy_o))
    else $error("closing result inconsistent with tour state");

  // a load never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (cmd_i == CMD_LOAD)) |=> !valid_o)
    else $error("load transaction produced a result");

endmodule

// ===== tb/tb_nearest_neighbor_tour_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_neighbor_tour_unit
// Self-checking bench for the greedy nearest neighbor tour unit. Weight loads
// and tour commands go in through the start/busy handshake with random gaps
// or back to back; a scoreboard replays each accepted transaction on its own
// copy of the weight store and registers, and checks every strobed city, cost
// and last flag in order. Every store entry a tour can read is loaded first.
// ----------------------------------------------------------------------------
module tb_nearest_neighbor_tour_unit;
  import nntu_pkg::*;

  localparam int MAX_CITIES    = 16;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_CYCLES  = 20;
  localparam int TARGET_ITEMS  = 450;

  typedef struct packed {
    logic [CITY_W-1:0] city;
    logic [COST_W-1:0] cost;
    logic              last;
  } tour_stop_t;

  class tour_scoreboard;
    logic [WEIGHT_IN_W-1:0] weights [MAX_CITIES][MAX_CITIES];
    logic [CNT_W-1:0]       city_count;
    logic [CFG_W-1:0]       no_edge;
    tour_stop_t             stops_due[$];
    int                     errors;

    function new();
      city_count = CITY_COUNT_RST;
      no_edge    = NO_EDGE_RST;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_CITY_COUNT) city_count = data[CNT_W-1:0];
      else if (idx == REG_NO_EDGE) no_edge = data;
    endfunction

    function int unsigned cities_in_use();
      if (city_count == 0) return 1;
      if (city_count > MAX_CITIES) return MAX_CITIES;
      return 32'(city_count);
    endfunction

    function void push_stop(int unsigned city, int unsigned cost, bit last);
      tour_stop_t s;
      s.city = CITY_W'(city);
      s.cost = COST_W'(cost);
      s.last = last;
      stops_due.push_back(s);
    endfunction

    function int unsigned add_cost(int unsigned cost, logic [WEIGHT_IN_W-1:0] w);
      int unsigned sum;
      sum = cost + 32'(w);
      return (sum > 32'(COST_MAX)) ? 32'(COST_MAX) : sum;
    endfunction

    function void plan_tour(logic [CITY_W-1:0] start_req);
      int unsigned n, first, here, best, cost;
      logic [WEIGHT_IN_W-1:0] w, best_w;
      bit [MAX_CITIES-1:0] visited;
      bit found;
      n = cities_in_use();
      first = (32'(start_req) >= n) ? n - 1 : 32'(start_req);
      visited = '0;
      visited[first] = 1'b1;
      here = first;
      cost = 0;
      best = 0;
      best_w = '0;
      push_stop(first, 0, 1'b0);
      while (1) begin
        found = 1'b0;
        for (int k = 0; k < n; k++) begin
          w = weights[here][k];
          if (w == 0 || w == no_edge || visited[k]) continue;
          if (!found || w < best_w) begin
            found = 1'b1;
            best = k;
            best_w = w;
          end
        end
        if (!found) break;
        cost = add_cost(cost, best_w);
        visited[best] = 1'b1;
        here = best;
        push_stop(best, 0, 1'b0);
      end
      // closing edge counts as stored, no-edge values included
      cost = add_cost(cost, weights[here][first]);
      push_stop(first, cost, 1'b1);
    endfunction

    function void note_item(logic cmd, logic [CITY_W-1:0] row, logic [CITY_W-1:0] col,
                            logic [WEIGHT_IN_W-1:0] w, logic [CITY_W-1:0] start_city);
      if (cmd == CMD_LOAD) weights[row][col] = w;
      else plan_tour(start_city);
    endfunction

    function void mismatch(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= 40)
        $display("%0t mismatch on %s: expected %0d actual %0d", $time, field, want, got);
    endfunction

    function void check_stop(logic [CITY_W-1:0] city, logic [COST_W-1:0] cost, logic last);
      tour_stop_t due;
      if (stops_due.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t unexpected result: expected none, actual city %0d cost %0d last %0d",
                   $time, city, cost, last);
        return;
      end
      due = stops_due.pop_front();
      if (city !== due.city) mismatch("city", 32'(due.city), 32'(city));
      if (cost !== due.cost) mismatch("total_cost", 32'(due.cost), 32'(cost));
      if (last !== due.last) mismatch("last", 32'(due.last), 32'(last));
    endfunction
  endclass

  logic                   clk_i        = 1'b0;
  logic                   rst_ni       = 1'b0;
  logic                   start_i      = 1'b0;
  logic                   busy_o;
  logic                   cmd_i        = CMD_LOAD;
  logic [CITY_W-1:0]      from_city_i  = '0;
  logic [CITY_W-1:0]      to_city_i    = '0;
  logic [WEIGHT_IN_W-1:0] weight_i     = '0;
  logic [CITY_W-1:0]      start_city_i = '0;
  logic                   valid_o;
  logic [CITY_W-1:0]      city_o;
  logic [COST_W-1:0]      total_cost_o;
  logic                   last_o;
  logic                   cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i    = REG_CITY_COUNT;
  logic [CFG_W-1:0]       cfg_data_i   = '0;

  tour_scoreboard sb = new();
  bit loaded [MAX_CITIES][MAX_CITIES];
  bit steady_sender = 1'b0;
  int items_sent = 0;
  int idle_cycles = 0;

  nearest_neighbor_tour_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .cmd_i        (cmd_i),
    .from_city_i  (from_city_i),
    .to_city_i    (to_city_i),
    .weight_i     (weight_i),
    .start_city_i (start_city_i),
    .valid_o      (valid_o),
    .city_o       (city_o),
    .total_cost_o (total_cost_o),
    .last_o       (last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // one sampling point for config, transactions, results and the watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_idx_i, cfg_data_i);
      if (start_i && !busy_o)
        sb.note_item(cmd_i, from_city_i, to_city_i, weight_i, start_city_i);
      if (valid_o) sb.check_stop(city_o, total_cost_o, last_o);
      if (cfg_we_i || (start_i && !busy_o) || valid_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_item(input logic cmd, input logic [CITY_W-1:0] row,
                           input logic [CITY_W-1:0] col, input logic [WEIGHT_IN_W-1:0] w,
                           input logic [CITY_W-1:0] start_city);
    int gap;
    gap = steady_sender ? 0 : int'($urandom_range(0, 10));
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    cmd_i        <= cmd;
    from_city_i  <= row;
    to_city_i    <= col;
    weight_i     <= w;
    start_city_i <= start_city;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
  endtask

  // writes only once the unit is quiet; start stays low until the next item
  task automatic set_config(input bit do_count, input logic [CFG_W-1:0] count_data,
                            input bit do_no_edge, input logic [CFG_W-1:0] no_edge_data);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.stops_due.size() != 0 || busy_o) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (do_count) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= REG_CITY_COUNT;
      cfg_data_i <= count_data;
      @(posedge clk_i);
    end
    if (do_no_edge) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= REG_NO_EDGE;
      cfg_data_i <= no_edge_data;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [WEIGHT_IN_W-1:0] pick_weight();
    int sel;
    sel = int'($urandom_range(0, 15));
    if (sel < 2) return '0;
    if (sel < 4) return sb.no_edge;
    if (sel == 4) return '1;
    if (sel < 9) return WEIGHT_IN_W'($urandom_range(1, 4));
    return WEIGHT_IN_W'($urandom_range(0, 65535));
  endfunction

  task automatic load_weight(input int row, input int col, input logic [WEIGHT_IN_W-1:0] w);
    loaded[row][col] = 1'b1;
    send_item(CMD_LOAD, CITY_W'(row), CITY_W'(col), w, CITY_W'($urandom_range(0, 15)));
  endtask

  // every entry the tour may read gets loaded before the tour goes in
  task automatic run_tour(input logic [CITY_W-1:0] start_city);
    int n;
    n = int'(sb.cities_in_use());
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        if (!loaded[r][c]) load_weight(r, c, pick_weight());
    send_item(CMD_TOUR, CITY_W'($urandom_range(0, 15)), CITY_W'($urandom_range(0, 15)),
              WEIGHT_IN_W'($urandom_range(0, 65535)), start_city);
  endtask

  initial begin
    int n, sel, episodes;
    logic [CFG_W-1:0] count_word, no_edge_word;
    logic [CNT_W-1:0] count_val;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // three cities: ties, zero and no-edge entries, heavy and no-edge closing edges
    set_config(1'b1, 16'd3, 1'b1, NO_EDGE_RST);
    load_weight(0, 0, 16'd0);
    load_weight(0, 1, 16'd7);
    load_weight(0, 2, 16'd7);
    load_weight(1, 0, 16'hFFFF);
    load_weight(1, 1, 16'd0);
    load_weight(1, 2, NO_EDGE_RST);
    load_weight(2, 0, 16'd3);
    load_weight(2, 1, NO_EDGE_RST);
    load_weight(2, 2, 16'd9);
    load_weight(15, 15, 16'hFFFF);
    run_tour(4'd0);
    run_tour(4'd15);
    run_tour(4'd1);
    // single city written with upper data bits set, then count zero read as one
    set_config(1'b1, 16'hFFE1, 1'b0, '0);
    run_tour(4'd0);
    set_config(1'b1, 16'h0000, 1'b0, '0);
    run_tour(4'd15);

    while (items_sent < TARGET_ITEMS) begin
      sel = int'($urandom_range(0, 9));
      case (sel)
        0: count_val = 5'd0;
        1: count_val = 5'd1;
        2: count_val = 5'd16;
        3: count_val = CNT_W'($urandom_range(17, 31));
        default: begin
          count_val = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(9, 16))
                                                  : CNT_W'($urandom_range(2, 8));
        end
      endcase
      count_word = CFG_W'($urandom_range(0, 65535));
      count_word[CNT_W-1:0] = count_val;
      sel = int'($urandom_range(0, 6));
      case (sel)
        0: no_edge_word = '0;
        1: no_edge_word = '1;
        2: no_edge_word = NO_EDGE_RST;
        3: no_edge_word = CFG_W'($urandom_range(1, 4));
        default: no_edge_word = CFG_W'($urandom_range(0, 65535));
      endcase
      set_config($urandom_range(0, 3) != 0, count_word, $urandom_range(0, 1) != 0,
                 no_edge_word);
      steady_sender = ($urandom_range(0, 3) == 0);
      episodes = int'($urandom_range(2, 6));
      repeat (episodes) begin
        if (items_sent < TARGET_ITEMS) begin
          n = int'(sb.cities_in_use());
          repeat ($urandom_range(0, 12)) begin
            if ($urandom_range(0, 4) == 0)
              load_weight(int'($urandom_range(0, 15)), int'($urandom_range(0, 15)),
                          pick_weight());
            else
              load_weight(int'($urandom_range(0, n - 1)), int'($urandom_range(0, n - 1)),
                          pick_weight());
          end
          run_tour(($urandom_range(0, 4) == 0) ? CITY_W'($urandom_range(0, 15))
                                               : CITY_W'($urandom_range(0, n - 1)));
        end
      end
    end

    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.stops_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
